// File: hdl/fed_pkg.sv
// fed_pkg: constants and register indexes for the feedback echo delay
// used by feedback_echo_delay and its testbench; no dependencies
package fed_pkg;

  localparam int LINE_DEPTH_DEF  = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_SYNC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_DIV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = 3'd6;

  // register widths
  localparam int MS_W   = 14;
  localparam int RATE_W = 18;
  localparam int BPM_W  = 9;
  localparam int FB_W   = 16;
  localparam int MIX_W  = 17;

  // register reset values
  localparam logic [MS_W-1:0]   MS_RST   = 14'd250;
  localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;
  localparam logic [1:0]        DIV_RST  = 2'd1;
  localparam logic [BPM_W-1:0]  BPM_RST  = 9'd120;
  localparam logic [FB_W-1:0]   FB_RST   = 16'd19661;
  localparam logic [MIX_W-1:0]  MIX_RST  = 17'd19661;

  // gain limits and decay factor
  localparam logic [FB_W-1:0]  FB_MAX    = 16'd62259;
  localparam logic [MIX_W-1:0] MIX_ONE   = 17'd65536;
  localparam logic [31:0]      DECAY_Q32 = 32'd4294881397;

  // delay length divider
  localparam int NUM_W = 32;
  localparam int DEN_W = 10;
  localparam int CNT_W = 6;
  localparam logic [DEN_W-1:0] MS_PER_S = 10'd1000;

endpackage

// File: hdl/fed_ram.sv
// fed_ram: simple dual-port ram, one write port, one registered read port
// depends on nothing
module fed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/feedback_echo_delay.sv
// feedback_echo_delay: feedback echo with free or tempo-synced delay length
// depends on fed_pkg and fed_ram
//
//   channel  signals                                         direction
//   in       in_valid, in_ready, dry_sample                  request in
//   out      out_valid, out_ready, mixed_sample, tail_level  request out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data       register write in
//
// a request goes through ram read, multiplies, rounding, write-back; one at a time
// the ring ram has one read and one write port; entries not yet written
// since reset read as zero via the write pointer and a wrap flag
// after reset and after every register write the delay length is
// recomputed by a bit-serial divider, with in_ready low meanwhile
// a result waiting in the output register stalls the write-back step and so holds in_ready low
module feedback_echo_delay #(
  parameter int LINE_DEPTH  = fed_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      dry_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      mixed_sample,
  output logic        [SAMPLE_BITS-1:0]      tail_level,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = SB + 18;
  localparam int RW = PW - 16;
  localparam logic [AW-1:0] DLY_MAX = AW'(LINE_DEPTH - 2);
  localparam logic [AW-1:0] IDX_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [AW:0] DEPTH_X = (AW + 1)'(LINE_DEPTH);
  localparam logic signed [PW-1:0] HALF = PW'(32768);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_WR   = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    DL_IDLE  = 4'b0001,
    DL_LOAD  = 4'b0010,
    DL_DIV   = 4'b0100,
    DL_CLAMP = 4'b1000
  } dl_state_t;

  // configuration registers
  logic [fed_pkg::MS_W-1:0]   delay_time_ms;
  logic [fed_pkg::RATE_W-1:0] sample_rate_hz;
  logic                       tempo_sync;
  logic [1:0]                 note_division;
  logic [fed_pkg::BPM_W-1:0]  tempo_bpm;
  logic [fed_pkg::FB_W-1:0]   feedback_gain;
  logic [fed_pkg::MIX_W-1:0]  wet_mix;

  logic cfg_req;
  assign cfg_ready = 1'b1;
  assign cfg_req   = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_time_ms  <= fed_pkg::MS_RST;
      sample_rate_hz <= fed_pkg::RATE_RST;
      tempo_sync     <= 1'b0;
      note_division  <= fed_pkg::DIV_RST;
      tempo_bpm      <= fed_pkg::BPM_RST;
      feedback_gain  <= fed_pkg::FB_RST;
      wet_mix        <= fed_pkg::MIX_RST;
    end else if (cfg_req) begin
      case (cfg_index)
        fed_pkg::CFG_DELAY_MS:    delay_time_ms  <= cfg_data[fed_pkg::MS_W-1:0];
        fed_pkg::CFG_SAMPLE_RATE: sample_rate_hz <= cfg_data[fed_pkg::RATE_W-1:0];
        fed_pkg::CFG_TEMPO_SYNC:  tempo_sync     <= cfg_data[0];
        fed_pkg::CFG_NOTE_DIV:    note_division  <= cfg_data[1:0];
        fed_pkg::CFG_TEMPO_BPM:   tempo_bpm      <= cfg_data[fed_pkg::BPM_W-1:0];
        fed_pkg::CFG_FB_GAIN:     feedback_gain  <= cfg_data[fed_pkg::FB_W-1:0];
        fed_pkg::CFG_WET_MIX:     wet_mix        <= cfg_data[fed_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // delay length: numerator, bit-serial divide, clamp
  dl_state_t                  dl_state, dl_state_next;
  logic [fed_pkg::NUM_W-1:0]  dl_num;
  logic [fed_pkg::DEN_W-1:0]  dl_den;
  logic [fed_pkg::DEN_W-1:0]  dl_rem;
  logic [fed_pkg::CNT_W-1:0]  dl_cnt;
  logic                       dl_zero;
  logic [AW-1:0]              delay;

  logic [fed_pkg::NUM_W-1:0]  free_num;
  logic [fed_pkg::NUM_W-1:0]  sync_num;
  logic [21:0]                rate15;
  logic [1:0]                 sync_shift;
  logic [fed_pkg::DEN_W:0]    trial;
  logic [fed_pkg::DEN_W:0]    diff;

  assign free_num   = fed_pkg::NUM_W'(delay_time_ms) * fed_pkg::NUM_W'(sample_rate_hz);
  assign rate15     = {sample_rate_hz, 4'b0} - 22'(sample_rate_hz);
  assign sync_shift = 2'd3 - note_division;
  assign sync_num   = fed_pkg::NUM_W'(rate15) << sync_shift;
  assign trial      = {dl_rem, dl_num[fed_pkg::NUM_W-1]};
  assign diff       = trial - {1'b0, dl_den};

  always_comb begin
    dl_state_next = dl_state;
    case (dl_state)
      DL_IDLE:  dl_state_next = DL_IDLE;
      DL_LOAD:  dl_state_next = DL_DIV;
      DL_DIV:   dl_state_next = (dl_cnt == fed_pkg::CNT_W'(1)) ? DL_CLAMP : DL_DIV;
      DL_CLAMP: dl_state_next = DL_IDLE;
      default:  dl_state_next = DL_LOAD;
    endcase
    if (cfg_req) begin
      dl_state_next = DL_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_state <= DL_LOAD;
    end else begin
      dl_state <= dl_state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (dl_state)
      DL_LOAD: begin
        dl_num  <= tempo_sync ? sync_num : free_num;
        dl_den  <= tempo_sync ? fed_pkg::DEN_W'(tempo_bpm) : fed_pkg::MS_PER_S;
        dl_zero <= tempo_sync && (tempo_bpm == '0);
        dl_rem  <= '0;
        dl_cnt  <= fed_pkg::CNT_W'(fed_pkg::NUM_W);
      end
      DL_DIV: begin
        if (!diff[fed_pkg::DEN_W]) begin
          dl_rem <= diff[fed_pkg::DEN_W-1:0];
          dl_num <= {dl_num[fed_pkg::NUM_W-2:0], 1'b1};
        end else begin
          dl_rem <= trial[fed_pkg::DEN_W-1:0];
          dl_num <= {dl_num[fed_pkg::NUM_W-2:0], 1'b0};
        end
        dl_cnt <= dl_cnt - fed_pkg::CNT_W'(1);
      end
      DL_CLAMP: begin
        if (dl_zero || dl_num > fed_pkg::NUM_W'(LINE_DEPTH - 2)) begin
          delay <= DLY_MAX;
        end else if (dl_num == '0) begin
          delay <= AW'(1);
        end else begin
          delay <= dl_num[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // request datapath
  state_t state, state_next;
  logic [AW-1:0] wr_idx;
  logic          wrapped;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   rd_wrap;
  logic          rd_hit;
  logic          in_req;
  logic          out_free;

  logic signed [SB-1:0] dry;
  logic        [SB-1:0] ram_rdata;
  logic signed [SB-1:0] wet;

  logic [fed_pkg::FB_W-1:0]  fb_eff;
  logic [fed_pkg::MIX_W-1:0] mix_eff;
  logic [fed_pkg::MIX_W-1:0] mix_inv;
  logic signed [PW-1:0] wet_x, dry_x, fb_x, mix_x, inv_x;
  logic signed [PW-1:0] p_fb, p_dry, p_wet;
  logic signed [PW-1:0] sum_fb, sum_mix;
  logic [SB+31:0]       dec_prod;
  logic [SB-1:0]        decayed;
  logic signed [RW-1:0] fb_rnd, mix_rnd;
  logic signed [RW-1:0] wr_sum;
  logic signed [SB-1:0] written, mixed;
  logic [SB-1:0]        mag;
  logic [SB-1:0]        peak_hold;

  assign in_ready = (state == ST_IDLE) && (dl_state == DL_IDLE);
  assign in_req   = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  assign rd_wrap = {1'b0, wr_idx} + DEPTH_X - {1'b0, delay};
  assign rd_addr = (wr_idx >= delay) ? (wr_idx - delay) : rd_wrap[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: state_next = in_req ? ST_MUL : ST_IDLE;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_WR;
      ST_WR:   state_next = out_free ? ST_IDLE : ST_WR;
      default: state_next = ST_IDLE;
    endcase
  end

  fed_ram #(
    .WIDTH(SB),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    ((state == ST_WR) && out_free),
    .waddr (wr_idx),
    .wdata (written),
    .re    (in_req),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // multiply stage operands
  assign wet     = rd_hit ? signed'(ram_rdata) : '0;
  assign fb_eff  = (feedback_gain > fed_pkg::FB_MAX) ? fed_pkg::FB_MAX : feedback_gain;
  assign mix_eff = (wet_mix > fed_pkg::MIX_ONE) ? fed_pkg::MIX_ONE : wet_mix;
  assign mix_inv = fed_pkg::MIX_ONE - mix_eff;
  assign wet_x   = PW'(wet);
  assign dry_x   = PW'(dry);
  assign fb_x    = signed'(PW'(fb_eff));
  assign mix_x   = signed'(PW'(mix_eff));
  assign inv_x   = signed'(PW'(mix_inv));
  assign dec_prod = (SB + 32)'(peak_hold) * (SB + 32)'(fed_pkg::DECAY_Q32);

  // rounding stage
  assign sum_fb  = p_fb + HALF;
  assign sum_mix = p_dry + p_wet + HALF;

  // write-back stage
  assign wr_sum = RW'(dry) + fb_rnd;

  always_comb begin
    if (!wr_sum[RW-1] && (|wr_sum[RW-2:SB-1])) begin
      written = {1'b0, {(SB-1){1'b1}}};
    end else if (wr_sum[RW-1] && !(&wr_sum[RW-2:SB-1])) begin
      written = {1'b1, {(SB-1){1'b0}}};
    end else begin
      written = wr_sum[SB-1:0];
    end
    if (!mix_rnd[RW-1] && (|mix_rnd[RW-2:SB-1])) begin
      mixed = {1'b0, {(SB-1){1'b1}}};
    end else if (mix_rnd[RW-1] && !(&mix_rnd[RW-2:SB-1])) begin
      mixed = {1'b1, {(SB-1){1'b0}}};
    end else begin
      mixed = mix_rnd[SB-1:0];
    end
  end

  assign mag = written[SB-1] ? (~written + SB'(1)) : written;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_idx    <= '0;
      wrapped   <= 1'b0;
      peak_hold <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WR && out_free) begin
        wr_idx    <= (wr_idx == IDX_LAST) ? '0 : wr_idx + AW'(1);
        wrapped   <= wrapped || (wr_idx == IDX_LAST);
        peak_hold <= (decayed > mag) ? decayed : mag;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      dry    <= dry_sample;
      rd_hit <= wrapped || (rd_addr < wr_idx);
    end
    if (state == ST_MUL) begin
      p_fb    <= wet_x * fb_x;
      p_dry   <= dry_x * inv_x;
      p_wet   <= wet_x * mix_x;
      decayed <= dec_prod[SB+31:32];
    end
    if (state == ST_SUM) begin
      fb_rnd  <= sum_fb[PW-1:16];
      mix_rnd <= sum_mix[PW-1:16];
    end
    if (state == ST_WR && out_free) begin
      mixed_sample <= mixed;
      tail_level   <= (decayed > mag) ? decayed : mag;
    end
  end

endmodule

// File: tb/tb_feedback_echo_delay.sv
// tb_feedback_echo_delay: self-checking bench for the feedback echo delay
// a scoreboard models the ring, the feedback write, the mix and the tail level for every request
// depends on fed_pkg and feedback_echo_delay
module tb_feedback_echo_delay;
  timeunit 1ns;
  timeprecision 1ps;

  import fed_pkg::*;

  localparam int DEPTH = LINE_DEPTH_DEF;
  localparam int SW = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [SW-1:0] level_t;
  typedef logic [CFG_DATA_W-1:0] reg_val_t;
  typedef longint unsigned u64_t;
  typedef struct {
    sample_t mixed;
    level_t  tail;
  } echo_out_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) << (SW-1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  class echo_scoreboard;
    int          mem [DEPTH];
    int unsigned wr_ptr;
    u64_t        peak;
    int unsigned delay_ms, rate_hz, sync_on, division, bpm, gain, mix;
    echo_out_t   expected [$];
    int          errors;

    function new();
      delay_ms = 32'(MS_RST);
      rate_hz  = 32'(RATE_RST);
      sync_on  = 0;
      division = 32'(DIV_RST);
      bpm      = 32'(BPM_RST);
      gain     = 32'(FB_RST);
      mix      = 32'(MIX_RST);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, reg_val_t val);
      case (idx)
        CFG_DELAY_MS:    delay_ms = 32'(val[MS_W-1:0]);
        CFG_SAMPLE_RATE: rate_hz  = 32'(val[RATE_W-1:0]);
        CFG_TEMPO_SYNC:  sync_on  = 32'(val[0]);
        CFG_NOTE_DIV:    division = 32'(val[1:0]);
        CFG_TEMPO_BPM:   bpm      = 32'(val[BPM_W-1:0]);
        CFG_FB_GAIN:     gain     = 32'(val[FB_W-1:0]);
        CFG_WET_MIX:     mix      = 32'(val[MIX_W-1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned echo_length();
      u64_t d;
      if (sync_on == 0) begin
        d = u64_t'(delay_ms) * rate_hz / 1000;
      end else if (bpm == 0) begin
        d = u64_t'(DEPTH);
      end else begin
        d = u64_t'(60) * rate_hz * (8 >> division) / (u64_t'(4) * bpm);
      end
      if (d < 1) d = 1;
      if (d > u64_t'(DEPTH - 2)) d = u64_t'(DEPTH - 2);
      return d[31:0];
    endfunction

    function longint q16(longint p);
      return (p + 32768) >>> 16;
    endfunction

    function longint clip(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function void note_sample(sample_t dry_in);
      longint      dry, wet, written, mixed, mag;
      u64_t        decayed;
      int unsigned rd, fb, m;
      echo_out_t   r;
      dry = longint'(dry_in);
      rd = (wr_ptr + DEPTH - echo_length()) % DEPTH;
      wet = longint'(mem[rd]);
      fb = (gain > FB_MAX) ? FB_MAX : gain;
      m = (mix > MIX_ONE) ? MIX_ONE : mix;
      written = clip(dry + q16(wet * longint'(fb)));
      mem[wr_ptr] = int'(written);
      wr_ptr = (wr_ptr + 1) % DEPTH;
      mag = (written < 0) ? -written : written;
      decayed = (peak * DECAY_Q32) >> 32;
      peak = (decayed > u64_t'(mag)) ? decayed : u64_t'(mag);
      mixed = clip(q16(dry * longint'(MIX_ONE - m) + wet * longint'(m)));
      r.mixed = mixed[SW-1:0];
      r.tail = peak[SW-1:0];
      expected.push_back(r);
    endfunction

    function int pending();
      return expected.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_result(sample_t got_mixed, level_t got_tail);
      echo_out_t r;
      if (expected.size() == 0) begin
        report($sformatf("result with no request pending: mixed %0d tail %0d",
                         got_mixed, got_tail));
      end else begin
        r = expected.pop_front();
        if (got_mixed !== r.mixed)
          report($sformatf("mixed_sample got %0d want %0d", got_mixed, r.mixed));
        if (got_tail !== r.tail)
          report($sformatf("tail_level got %0d want %0d", got_tail, r.tail));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sample_t                dry_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sample_t                mixed_sample;
  level_t                 tail_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  reg_val_t               cfg_data = '0;

  echo_scoreboard sb;
  int unsigned    send_gap_pct = 0;
  int unsigned    ready_drop_pct = 0;
  int unsigned    hold_req = 0;
  int unsigned    hold_left = 0;
  int unsigned    cycles = 0;

  feedback_echo_delay dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dry_sample   (dry_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mixed_sample (mixed_sample),
    .tail_level   (tail_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("feedback_echo_delay test failed");
      $finish;
    end
  end

  // receiver side, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (ready_drop_pct == 0) || ($urandom_range(99) >= ready_drop_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(mixed_sample, tail_level);
  end

  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    dry_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input reg_val_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_echo(input reg_val_t ms, input reg_val_t rate, input reg_val_t sync,
                          input reg_val_t div, input reg_val_t bpm, input reg_val_t fb,
                          input reg_val_t mx);
    set_register(CFG_DELAY_MS, ms);
    set_register(CFG_SAMPLE_RATE, rate);
    set_register(CFG_TEMPO_SYNC, sync);
    set_register(CFG_NOTE_DIV, div);
    set_register(CFG_TEMPO_BPM, bpm);
    set_register(CFG_FB_GAIN, fb);
    set_register(CFG_WET_MIX, mx);
  endtask

  // lower the request and wait for every pending result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  ready_drop_pct = 0;  end
      1: begin send_gap_pct = 51; ready_drop_pct = 0;  end
      2: begin send_gap_pct = 0;  ready_drop_pct = 51; end
      default: begin send_gap_pct = 34; ready_drop_pct = 34; end
    endcase
  endtask

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return S_MAX;
    if (pick == 1) return S_MIN;
    if (pick <= 4) return '0;
    if (pick == 5) return sample_t'($signed($urandom_range(64)) - 32);
    return sample_t'($urandom);
  endfunction

  initial begin
    sample_t  corners [8];
    int       k, i, n;
    reg_val_t ms, rate, sync, div, bpm, fb, mx;
    corners = '{S_MAX, S_MIN, '0, '1, sample_t'(1), sample_t'(24'h555555),
                sample_t'(24'haaaaaa), sample_t'(-2)};
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings, echo far beyond the run
    foreach (corners[j]) send_sample(corners[j]);
    settle();

    // one-sample delay with clamped gain and mix, saturating both ways
    set_echo(0, 48000, 0, 1, 120, 18'd65535, 18'd131071);
    repeat (4) send_sample(S_MAX);
    repeat (4) send_sample(S_MIN);
    send_sample('0);
    send_sample(sample_t'(1));
    send_sample('1);
    settle();

    // zero tempo in sync mode, longest settings, spare register index
    set_echo(18'd16383, 18'd262143, 1, 3, 0, 0, 0);
    set_register(CFG_SPARE, 18'h3ffff);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(sample_t'(3));
    settle();
    set_register(CFG_TEMPO_SYNC, 0);
    send_sample(S_MIN);
    send_sample(S_MAX);
    settle();

    for (k = 0; k < 12; k++) begin
      sync = reg_val_t'($urandom_range(1));
      ms = reg_val_t'($urandom_range(25));
      rate = (sync != 0) ? reg_val_t'($urandom_range(100, 4000))
                         : reg_val_t'($urandom_range(2000, 40000));
      div = reg_val_t'($urandom_range(3));
      bpm = reg_val_t'($urandom_range(20, 511));
      if (k == 9) begin
        sync = 0;
        ms = 10000;
        rate = 192000;
      end
      case (k % 4)
        0: fb = 0;
        1: fb = reg_val_t'(FB_MAX);
        2: fb = 18'd65535;
        default: fb = reg_val_t'($urandom_range(FB_MAX));
      endcase
      case ((k + 1) % 4)
        0: mx = 0;
        1: mx = reg_val_t'(MIX_ONE);
        2: mx = reg_val_t'($urandom_range(65537, 131071));
        default: mx = reg_val_t'($urandom_range(MIX_ONE));
      endcase
      set_echo(ms, rate, sync, div, bpm, fb, mx);
      set_idle(k % 4);
      n = $urandom_range(100, 115);
      for (i = 0; i < n; i++) begin
        if (k == 4 && i == 3) hold_req = 300;
        if (k == 6 && i == n / 2) settle();
        send_sample(rand_sample());
      end
      settle();
    end

    if (sb.pending() != 0) sb.report("requests left without a result");
    if (sb.errors == 0) begin
      $display("feedback_echo_delay test passed");
    end else begin
      $display("feedback_echo_delay test failed");
    end
    $finish;
  end

endmodule
